// ===== design/qrs_pkg.sv =====
// Shared types, constants and arithmetic step functions for the quadratic root solver.
`default_nettype none
package qrs_pkg;

  localparam int COEF_W   = 16;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int DISC_W   = PROD_W + 2;
  localparam int RAD_W    = 2 * DISC_W;
  localparam int SQ_STEPS = DISC_W - 1;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SQREM_W  = ROOT_W + 3;
  localparam int NUM_W    = DISC_W;
  localparam int DV_STEPS = NUM_W;
  localparam int DEN_W    = COEF_W + 1;
  localparam int DVREM_W  = DEN_W + 1;
  localparam int WIDE_W   = NUM_W + 2;
  localparam int RES_W    = 32;
  localparam int OUT_FRAC = 16;

  typedef enum logic [2:0] {
    KIND_TWO_REAL   = 3'd0,
    KIND_COMPLEX    = 3'd1,
    KIND_DOUBLE     = 3'd2,
    KIND_LINEAR     = 3'd3,
    KIND_IMPOSSIBLE = 3'd4,
    KIND_IDENTITY   = 3'd5
  } kind_t;

  // Context carried alongside the square-root stages.
  typedef struct packed {
    kind_t                     kind;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
  } sq_ctx_t;

  // Context carried alongside the division stages.
  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
    logic  a_neg;
  } dv_ctx_t;

  typedef struct packed {
    logic [SQREM_W-1:0] rem;
    logic [ROOT_W-1:0]  root;
    logic [RAD_W-1:0]   x;
  } sq_state_t;

  typedef struct packed {
    logic [DVREM_W-1:0] rem;
    logic [NUM_W-1:0]   quo;
    logic [NUM_W-1:0]   num;
  } dv_state_t;

  typedef struct packed {
    logic             sat;
    logic [RES_W-1:0] val;
  } fix_t;

  function automatic logic [COEF_W-1:0] abs_coef(input logic signed [COEF_W-1:0] v);
    abs_coef = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
  endfunction

  // One digit of the restoring square root.
  function automatic sq_state_t sq_step(input sq_state_t s);
    sq_state_t          r;
    logic [SQREM_W-1:0] rs;
    logic [SQREM_W-1:0] trial;
    logic               ge;
    rs     = {s.rem[SQREM_W-3:0], s.x[RAD_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    ge     = (rs >= trial);
    r.rem  = ge ? (rs - trial) : rs;
    r.root = {s.root[ROOT_W-2:0], ge};
    r.x    = {s.x[RAD_W-3:0], 2'b00};
    return r;
  endfunction

  // One bit of the restoring division.
  function automatic dv_state_t dv_step(input dv_state_t s, input logic [DEN_W-1:0] d);
    dv_state_t          r;
    logic [DVREM_W-1:0] rs;
    logic               ge;
    rs    = {s.rem[DVREM_W-2:0], s.num[NUM_W-1]};
    ge    = (rs >= {1'b0, d});
    r.rem = ge ? (rs - {1'b0, d}) : rs;
    r.quo = {s.quo[NUM_W-2:0], ge};
    r.num = {s.num[NUM_W-2:0], 1'b0};
    return r;
  endfunction

  // Applies the sign to a quotient magnitude and clips to the signed result range.
  function automatic fix_t fix_result(input logic [NUM_W-1:0] q, input logic neg);
    fix_t r;
    r.sat = 1'b0;
    if (neg && (q != '0)) begin
      if (q > (NUM_W'(1) << (RES_W - 1))) begin
        r.sat = 1'b1;
        r.val = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
        r.val = RES_W'(-q);
      end
    end else begin
      if (q > NUM_W'({1'b0, {(RES_W-1){1'b1}}})) begin
        r.sat = 1'b1;
        r.val = {1'b0, {(RES_W-1){1'b1}}};
      end else begin
        r.val = q[RES_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/quadratic_root_solver_core.sv =====
// Pipelined quadratic root solver: discriminant, square root, divisions and saturation.
// Depth: 72 register stages from the coefficient capture to the output register.
// Throughput: one transaction per cycle unless the output stalls; the square root takes
// one stage per result bit (33 stages), the two dividers one per quotient bit (34 stages).
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (synchronous, active high) clears every valid bit; payload registers are not reset.
`default_nettype none
module quadratic_root_solver_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] coef_a,
  input  wire logic signed [15:0] coef_b,
  input  wire logic signed [15:0] coef_c,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              root_kind,
  output logic signed [31:0]      first_real,
  output logic signed [31:0]      second_real,
  output logic signed [31:0]      first_imag,
  output logic signed [31:0]      second_imag,
  output logic                    saturated
);

  // Every stage moves on together; a stall freezes the whole pipe, so nothing is lost.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 0: capture the coefficients.
  logic                                  v0;
  logic signed [qrs_pkg::COEF_W-1:0]     a0, b0, c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      a0 <= coef_a;
      b0 <= coef_b;
      c0 <= coef_c;
    end
  end

  // Stage 1: the two magnitude products |b|^2 and |a||c|.
  logic                                  v1;
  logic signed [qrs_pkg::COEF_W-1:0]     a1, b1, c1;
  logic [qrs_pkg::PROD_W-1:0]            p1, q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      a1 <= a0;
      b1 <= b0;
      c1 <= c0;
      p1 <= qrs_pkg::abs_coef(b0) * qrs_pkg::abs_coef(b0);
      q1 <= qrs_pkg::abs_coef(a0) * qrs_pkg::abs_coef(c0);
    end
  end

  // Stage 2: exact discriminant magnitude, its sign, and the classification.
  logic                                  v2;
  qrs_pkg::sq_ctx_t                      ctx2;
  logic [qrs_pkg::DISC_W-1:0]            dmag2;

  logic [qrs_pkg::DISC_W-1:0]            p_ext, q4_ext, dmag_c;
  logic                                  sub_c, dneg_c;
  qrs_pkg::kind_t                        kind_c;

  always_comb begin
    p_ext  = qrs_pkg::DISC_W'(p1);
    q4_ext = {q1, 2'b00};
    // Subtraction happens only when a and c are non-zero with the same sign.
    sub_c  = (a1 != '0) && (c1 != '0) && (a1[qrs_pkg::COEF_W-1] == c1[qrs_pkg::COEF_W-1]);
    dneg_c = sub_c && (p_ext < q4_ext);
    if (!sub_c) begin
      dmag_c = p_ext + q4_ext;
    end else if (dneg_c) begin
      dmag_c = q4_ext - p_ext;
    end else begin
      dmag_c = p_ext - q4_ext;
    end
    if (dmag_c == '0) begin
      if ((a1 == '0) && (b1 == '0)) begin
        kind_c = (c1 != '0) ? qrs_pkg::KIND_IMPOSSIBLE : qrs_pkg::KIND_IDENTITY;
      end else begin
        kind_c = qrs_pkg::KIND_DOUBLE;
      end
    end else if (!dneg_c) begin
      kind_c = (a1 == '0) ? qrs_pkg::KIND_LINEAR : qrs_pkg::KIND_TWO_REAL;
    end else begin
      kind_c = qrs_pkg::KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      ctx2.kind <= kind_c;
      ctx2.a    <= a1;
      ctx2.b    <= b1;
      ctx2.c    <= c1;
      dmag2     <= dmag_c;
    end
  end

  // Square-root stages: one result bit per stage, radicand |D| * 2^32.
  logic                 sq_v   [1:qrs_pkg::SQ_STEPS];
  qrs_pkg::sq_ctx_t     sq_ctx [1:qrs_pkg::SQ_STEPS];
  qrs_pkg::sq_state_t   sq_st  [1:qrs_pkg::SQ_STEPS];

  genvar k;
  generate
    for (k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sqrt
      logic               vin;
      qrs_pkg::sq_ctx_t   cin;
      qrs_pkg::sq_state_t sin;
      if (k == 0) begin : g_first
        always_comb begin
          vin      = v2;
          cin      = ctx2;
          sin.rem  = '0;
          sin.root = '0;
          sin.x    = {dmag2, {qrs_pkg::DISC_W{1'b0}}};
        end
      end else begin : g_next
        always_comb begin
          vin = sq_v[k];
          cin = sq_ctx[k];
          sin = sq_st[k];
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          sq_v[k+1] <= 1'b0;
        end else if (adv) begin
          sq_v[k+1] <= vin;
        end
        if (adv) begin
          sq_ctx[k+1] <= cin;
          sq_st[k+1]  <= qrs_pkg::sq_step(sin);
        end
      end
    end
  endgenerate

  // Numerator stage: form signed numerators, their magnitudes and the result signs.
  logic                                  vn;
  qrs_pkg::dv_ctx_t                      ctxn;
  logic [qrs_pkg::NUM_W-1:0]             n1n, n2n;
  logic [qrs_pkg::DEN_W-1:0]             dn;

  qrs_pkg::sq_ctx_t                      sc;
  logic [qrs_pkg::ROOT_W-1:0]            s_root;
  logic signed [qrs_pkg::WIDE_W-1:0]     bw, nbw, sw, num1, num2;
  logic [qrs_pkg::NUM_W-1:0]             n1_c, n2_c;
  logic [qrs_pkg::DEN_W-1:0]             d_c;
  logic                                  neg1_c, neg2_c, a_neg_c;

  always_comb begin
    sc      = sq_ctx[qrs_pkg::SQ_STEPS];
    s_root  = sq_st[qrs_pkg::SQ_STEPS].root;
    a_neg_c = sc.a[qrs_pkg::COEF_W-1];
    bw      = qrs_pkg::WIDE_W'(sc.b);
    nbw     = -(bw <<< qrs_pkg::OUT_FRAC);
    sw      = $signed(qrs_pkg::WIDE_W'(s_root));
    num1    = nbw + sw;
    num2    = nbw - sw;
    d_c     = {qrs_pkg::abs_coef(sc.a), 1'b0};
    n2_c    = qrs_pkg::NUM_W'(s_root);
    neg2_c  = 1'b0;
    case (sc.kind)
      qrs_pkg::KIND_TWO_REAL: begin
        n1_c   = num1[qrs_pkg::WIDE_W-1] ? qrs_pkg::NUM_W'(-num1) : qrs_pkg::NUM_W'(num1);
        n2_c   = num2[qrs_pkg::WIDE_W-1] ? qrs_pkg::NUM_W'(-num2) : qrs_pkg::NUM_W'(num2);
        neg1_c = num1[qrs_pkg::WIDE_W-1] ^ a_neg_c;
        neg2_c = num2[qrs_pkg::WIDE_W-1] ^ a_neg_c;
      end
      qrs_pkg::KIND_LINEAR: begin
        // Numerator is -c * 2^16 and the divisor is b.
        n1_c   = qrs_pkg::NUM_W'({qrs_pkg::abs_coef(sc.c), {qrs_pkg::OUT_FRAC{1'b0}}});
        n2_c   = n1_c;
        d_c    = qrs_pkg::DEN_W'(qrs_pkg::abs_coef(sc.b));
        neg1_c = ((sc.c != '0) && !sc.c[qrs_pkg::COEF_W-1]) ^ sc.b[qrs_pkg::COEF_W-1];
        neg2_c = neg1_c;
      end
      default: begin
        n1_c   = nbw[qrs_pkg::WIDE_W-1] ? qrs_pkg::NUM_W'(-nbw) : qrs_pkg::NUM_W'(nbw);
        neg1_c = nbw[qrs_pkg::WIDE_W-1] ^ a_neg_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (adv) begin
      vn <= sq_v[qrs_pkg::SQ_STEPS];
    end
    if (adv) begin
      ctxn.kind  <= sc.kind;
      ctxn.neg1  <= neg1_c;
      ctxn.neg2  <= neg2_c;
      ctxn.a_neg <= a_neg_c;
      n1n        <= n1_c;
      n2n        <= n2_c;
      dn         <= d_c;
    end
  end

  // Division stages: two restoring dividers sharing one divisor, one quotient bit per stage.
  logic                      dv_v   [1:qrs_pkg::DV_STEPS];
  qrs_pkg::dv_ctx_t          dv_ctx [1:qrs_pkg::DV_STEPS];
  logic [qrs_pkg::DEN_W-1:0] dv_d   [1:qrs_pkg::DV_STEPS];
  qrs_pkg::dv_state_t        dv_s1  [1:qrs_pkg::DV_STEPS];
  qrs_pkg::dv_state_t        dv_s2  [1:qrs_pkg::DV_STEPS];

  genvar j;
  generate
    for (j = 0; j < qrs_pkg::DV_STEPS; j++) begin : g_div
      logic                      vin;
      qrs_pkg::dv_ctx_t          cin;
      logic [qrs_pkg::DEN_W-1:0] din;
      qrs_pkg::dv_state_t        s1in, s2in;
      if (j == 0) begin : g_first
        always_comb begin
          vin      = vn;
          cin      = ctxn;
          din      = dn;
          s1in.rem = '0;
          s1in.quo = '0;
          s1in.num = n1n;
          s2in.rem = '0;
          s2in.quo = '0;
          s2in.num = n2n;
        end
      end else begin : g_next
        always_comb begin
          vin  = dv_v[j];
          cin  = dv_ctx[j];
          din  = dv_d[j];
          s1in = dv_s1[j];
          s2in = dv_s2[j];
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_v[j+1] <= 1'b0;
        end else if (adv) begin
          dv_v[j+1] <= vin;
        end
        if (adv) begin
          dv_ctx[j+1] <= cin;
          dv_d[j+1]   <= din;
          dv_s1[j+1]  <= qrs_pkg::dv_step(s1in, din);
          dv_s2[j+1]  <= qrs_pkg::dv_step(s2in, din);
        end
      end
    end
  endgenerate

  // Output stage: sign, clip and select the fields by root kind.
  qrs_pkg::dv_ctx_t cf;
  qrs_pkg::fix_t    f_r1, f_r2, f_i1, f_i2;
  logic [31:0]      r1_c, r2_c, i1_c, i2_c;
  logic             sat_c;

  always_comb begin
    cf    = dv_ctx[qrs_pkg::DV_STEPS];
    f_r1  = qrs_pkg::fix_result(dv_s1[qrs_pkg::DV_STEPS].quo, cf.neg1);
    f_r2  = qrs_pkg::fix_result(dv_s2[qrs_pkg::DV_STEPS].quo, cf.neg2);
    f_i1  = qrs_pkg::fix_result(dv_s2[qrs_pkg::DV_STEPS].quo, !cf.a_neg);
    f_i2  = qrs_pkg::fix_result(dv_s2[qrs_pkg::DV_STEPS].quo, cf.a_neg);
    r1_c  = f_r1.val;
    r2_c  = f_r1.val;
    i1_c  = '0;
    i2_c  = '0;
    sat_c = f_r1.sat;
    case (cf.kind)
      qrs_pkg::KIND_TWO_REAL: begin
        r2_c  = f_r2.val;
        sat_c = f_r1.sat | f_r2.sat;
      end
      qrs_pkg::KIND_COMPLEX: begin
        i1_c  = f_i1.val;
        i2_c  = f_i2.val;
        sat_c = f_r1.sat | f_i1.sat | f_i2.sat;
      end
      qrs_pkg::KIND_DOUBLE, qrs_pkg::KIND_LINEAR: begin
      end
      default: begin
        // No roots to report; the divisor was zero here.
        r1_c  = '0;
        r2_c  = '0;
        sat_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[qrs_pkg::DV_STEPS];
    end
    if (adv) begin
      root_kind   <= cf.kind;
      first_real  <= r1_c;
      second_real <= r2_c;
      first_imag  <= i1_c;
      second_imag <= i2_c;
      saturated   <= sat_c;
    end
  end

  // Checks on the result selection.
  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((root_kind == qrs_pkg::KIND_IMPOSSIBLE) ||
                  (root_kind == qrs_pkg::KIND_IDENTITY))
    |-> (first_real == '0) && (second_real == '0) && !saturated)
    else $error("roots reported for an equation without roots");

  a_imag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_kind != qrs_pkg::KIND_COMPLEX)
    |-> (first_imag == '0) && (second_imag == '0))
    else $error("imaginary part outside a complex pair");

  a_equal_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_kind != qrs_pkg::KIND_TWO_REAL) |-> (first_real == second_real))
    else $error("real parts differ for a single real value");

  a_conj: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_kind == qrs_pkg::KIND_COMPLEX) && !saturated
    |-> (first_imag == -second_imag) && (first_imag != '0))
    else $error("complex pair is not conjugate");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the pipelined quadratic root solver core.
`default_nettype none
module tb;

  // One answer from the solver, laid out as the output ports are.
  typedef struct {
    qrs_pkg::kind_t kind;
    logic [31:0]    re1;
    logic [31:0]    re2;
    logic [31:0]    im1;
    logic [31:0]    im2;
    logic           sat;
  } roots_t;

  // One row of the directed table. Where known is set, the answer is typed in.
  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    bit                 known;
    roots_t             ans;
  } coef_row_t;

  localparam int  HALF_PERIOD    = 10;
  localparam int  STALL_LIMIT    = 3000;
  localparam int  PIPE_DRAIN     = 100;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  RANDOM_PER_PHASE = 325;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] coef_a = '0;
  logic signed [15:0] coef_b = '0;
  logic signed [15:0] coef_c = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         root_kind;
  logic signed [31:0] first_real;
  logic signed [31:0] second_real;
  logic signed [31:0] first_imag;
  logic signed [31:0] second_imag;
  logic               saturated;

  // Side information travelling with the offered transaction.
  bit                 cur_known = 1'b0;
  roots_t             cur_ans;

  roots_t pending_roots[$];
  int     mismatches  = 0;
  int     n_sent      = 0;
  int     n_checked   = 0;
  int     n_saturated = 0;
  int     kind_seen[6];
  int     idle_pct    = 0;
  int     stall_pct   = 0;
  bit     start_hold  = 1'b0;
  bit     hold_done   = 1'b0;
  int     hold_left   = 0;
  int     quiet_cycles = 0;

  quadratic_root_solver_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .coef_c      (coef_c),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .root_kind   (root_kind),
    .first_real  (first_real),
    .second_real (second_real),
    .first_imag  (first_imag),
    .second_imag (second_imag),
    .saturated   (saturated)
  );

  always #HALF_PERIOD clk = ~clk;

  // Truncating division of a Q16.16 numerator, clipped to the signed 32-bit range.
  function automatic logic [31:0] clip_quot(input longint num, input longint den,
                                            inout bit sat);
    longint nm;
    longint dm;
    longint q;
    bit     neg;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    if (dm == 0) return '0;
    q   = nm / dm;
    neg = ((num < 0) != (den < 0)) && (q != 0);
    if (neg) begin
      if (q > 64'sh8000_0000) begin
        q   = 64'sh8000_0000;
        sat = 1'b1;
      end
      return 32'(-q);
    end
    if (q > 64'sh7FFF_FFFF) begin
      q   = 64'sh7FFF_FFFF;
      sat = 1'b1;
    end
    return 32'(q);
  endfunction

  // Works out the roots of a*x^2 + b*x + c from the raw coefficient integers.
  function automatic roots_t solve_roots(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
    roots_t       r;
    longint       ai;
    longint       bi;
    longint       ci;
    longint       disc;
    longint       nb;
    longint       den;
    longint       sq;
    logic [127:0] rad;
    logic [127:0] trial;
    logic [63:0]  root;
    bit           sat;
    ai   = longint'(a);
    bi   = longint'(b);
    ci   = longint'(c);
    sat  = 1'b0;
    disc = bi * bi - 4 * ai * ci;
    rad  = 128'(disc < 0 ? -disc : disc) << 32;
    root = '0;
    // Bitwise integer square root of |D| scaled by 2^32.
    for (int k = 63; k >= 0; k--) begin
      trial = 128'(root | (64'd1 << k));
      if (trial * trial <= rad) root = trial[63:0];
    end
    sq    = longint'(root);
    nb    = -(bi * 65536);
    den   = 2 * ai;
    r.re1 = '0;
    r.re2 = '0;
    r.im1 = '0;
    r.im2 = '0;
    if (disc == 0) begin
      if (ai == 0 && bi == 0) begin
        r.kind = (ci != 0) ? qrs_pkg::KIND_IMPOSSIBLE : qrs_pkg::KIND_IDENTITY;
      end else begin
        r.kind = qrs_pkg::KIND_DOUBLE;
        r.re1  = clip_quot(nb, den, sat);
        r.re2  = r.re1;
      end
    end else if (disc > 0) begin
      if (ai == 0) begin
        r.kind = qrs_pkg::KIND_LINEAR;
        r.re1  = clip_quot(-(ci * 65536), bi, sat);
        r.re2  = r.re1;
      end else begin
        r.kind = qrs_pkg::KIND_TWO_REAL;
        r.re1  = clip_quot(nb + sq, den, sat);
        r.re2  = clip_quot(nb - sq, den, sat);
      end
    end else begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.re1  = clip_quot(nb, den, sat);
      r.re2  = r.re1;
      r.im1  = clip_quot(-sq, den, sat);
      r.im2  = clip_quot(sq, den, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic roots_t mk_roots(input qrs_pkg::kind_t k, input logic [31:0] r1,
                                      input logic [31:0] r2, input logic [31:0] i1,
                                      input logic [31:0] i2, input logic s);
    roots_t r;
    r.kind = k;
    r.re1  = r1;
    r.re2  = r2;
    r.im1  = i1;
    r.im2  = i2;
    r.sat  = s;
    return r;
  endfunction

  // Input side: every accepted transaction queues the answer it must produce.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_roots.push_back(cur_known ? cur_ans : solve_roots(coef_a, coef_b, coef_c));
      n_sent++;
    end
  end

  // Output side: each result is compared with the oldest outstanding answer.
  always @(posedge clk) begin
    roots_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, root_kind);
        mismatches++;
      end else begin
        want = pending_roots.pop_front();
        n_checked++;
        if (root_kind < 6) kind_seen[root_kind]++;
        if (saturated) n_saturated++;
        if (root_kind !== want.kind) begin
          $display("%0t: root_kind expected %0d got %0d", $time, want.kind, root_kind);
          mismatches++;
        end
        if (first_real !== want.re1) begin
          $display("%0t: first_real expected %h got %h", $time, want.re1, first_real);
          mismatches++;
        end
        if (second_real !== want.re2) begin
          $display("%0t: second_real expected %h got %h", $time, want.re2, second_real);
          mismatches++;
        end
        if (first_imag !== want.im1) begin
          $display("%0t: first_imag expected %h got %h", $time, want.im1, first_imag);
          mismatches++;
        end
        if (second_imag !== want.im2) begin
          $display("%0t: second_imag expected %h got %h", $time, want.im2, second_imag);
          mismatches++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, saturated);
          mismatches++;
        end
      end
    end
  end

  // The receiver stalls at random, except during the single long hold-off, in which
  // the sender keeps offering transactions until the pipeline fills and in_ready drops.
  always @(posedge clk) begin
    if (start_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: the run is abandoned if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_roots.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Offers one transaction after a random idle gap and waits until it is taken.
  task automatic offer_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic signed [15:0] c, input bit known,
                             input roots_t ans);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    coef_a    <= a;
    coef_b    <= b;
    coef_c    <= c;
    cur_known <= known;
    cur_ans   <= ans;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random coefficients, shaped so that every root kind and saturation turn up often.
  function automatic logic signed [15:0] pick_coef(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  task automatic random_coefs();
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] t;
    int                 shape;
    roots_t             none;
    shape = $urandom_range(9);
    a = pick_coef($urandom_range(3));
    b = pick_coef($urandom_range(3));
    c = pick_coef($urandom_range(3));
    case (shape)
      0: a = '0;                     // linear, or impossible/identity when b is zero
      1: begin
        a = '0;
        b = '0;
        if ($urandom_range(1)) c = '0;
      end
      2: begin                       // double root a*(x-t)^2, small t; identity when a=0
        t = 16'($signed($urandom_range(16)) - 8);
        a = 16'($signed($urandom_range(16)) - 8);
        b = 16'(-2 * a * t);
        c = 16'(a * t * t);
      end
      3: c = '0;
      4: begin                       // tiny a with large b drives the roots into saturation
        a = 16'($signed($urandom_range(4)) - 2);
        b = pick_coef(2);
      end
      default: ;
    endcase
    none = mk_roots(qrs_pkg::KIND_IDENTITY, '0, '0, '0, '0, 1'b0);
    offer_coefs(a, b, c, 1'b0, none);
  endtask

  task automatic wait_drained();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  coef_row_t directed_rows[$];
  int        idle_sets[4]  = '{0, 75, 0, 10};
  int        stall_sets[4] = '{0, 0, 75, 10};

  initial begin
    roots_t none;
    none = mk_roots(qrs_pkg::KIND_IDENTITY, '0, '0, '0, '0, 1'b0);
    // The obvious cases carry their answers; the rest go through the predictor.
    directed_rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1,
        mk_roots(qrs_pkg::KIND_IDENTITY, '0, '0, '0, '0, 1'b0)},
      '{16'sd0, 16'sd0, 16'sd5, 1'b1,
        mk_roots(qrs_pkg::KIND_IMPOSSIBLE, '0, '0, '0, '0, 1'b0)},
      '{16'sd0, 16'sd0, -16'sd32768, 1'b1,
        mk_roots(qrs_pkg::KIND_IMPOSSIBLE, '0, '0, '0, '0, 1'b0)},
      '{16'sd256, 16'sd0, -16'sd256, 1'b1,
        mk_roots(qrs_pkg::KIND_TWO_REAL, 32'h0001_0000, 32'hFFFF_0000, '0, '0, 1'b0)},
      '{16'sd256, -16'sd512, 16'sd256, 1'b1,
        mk_roots(qrs_pkg::KIND_DOUBLE, 32'h0001_0000, 32'h0001_0000, '0, '0, 1'b0)},
      '{16'sd0, 16'sd256, -16'sd512, 1'b1,
        mk_roots(qrs_pkg::KIND_LINEAR, 32'h0002_0000, 32'h0002_0000, '0, '0, 1'b0)},
      '{16'sd256, 16'sd0, 16'sd256, 1'b1,
        mk_roots(qrs_pkg::KIND_COMPLEX, '0, '0, 32'hFFFF_0000, 32'h0001_0000, 1'b0)},
      '{16'sd1, -16'sd32768, 16'sd0, 1'b1,
        mk_roots(qrs_pkg::KIND_TWO_REAL, 32'h7FFF_FFFF, '0, '0, '0, 1'b1)},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, none},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, none},
      '{-16'sd32768, 16'sd32767, 16'sd32767, 1'b0, none},
      '{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, none},
      '{16'sd1, 16'sd0, 16'sd32767, 1'b0, none},
      '{16'sd1, 16'sd32767, 16'sd1, 1'b0, none},
      '{-16'sd1, 16'sd0, -16'sd32768, 1'b0, none},
      '{16'sd0, 16'sd1, 16'sd32767, 1'b0, none},
      '{16'sd0, 16'sd1, -16'sd32768, 1'b0, none},
      '{16'sd0, -16'sd32768, 16'sd1, 1'b0, none},
      '{16'sd32767, 16'sd1, -16'sd1, 1'b0, none},
      '{-16'sd1, 16'sd2, -16'sd1, 1'b0, none},
      '{16'sd3, 16'sd5, 16'sd7, 1'b0, none},
      '{-16'sd3, 16'sd5, 16'sd7, 1'b0, none}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_sets[ph];
      stall_pct = stall_sets[ph];
      if (ph == 0) begin
        foreach (directed_rows[i])
          offer_coefs(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                      directed_rows[i].known, directed_rows[i].ans);
        start_hold <= 1'b1;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_coefs();
    end
    in_valid  <= 1'b0;
    cur_known <= 1'b0;

    wait_drained();
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("tb: %0d coefficient sets solved, %0d saturated; kinds two-real %0d, complex %0d,",
             n_checked, n_saturated, kind_seen[0], kind_seen[1]);
    $display("tb: double %0d, linear %0d, impossible %0d, identity %0d, under four flow phases",
             kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== quadratic_root_solver_core.f =====
design/qrs_pkg.sv
design/quadratic_root_solver_core.sv
sim/tb.sv
